/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the checker files.
// Both macros expect signals named clk and rst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

/* rtl/core/ffba_pkg.sv */
package ffba_pkg;

    // Table geometry.
    localparam int MAX_BLOCKS = 64;
    localparam int SIZE_BITS  = 32;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // Largest storable size, in a 64-bit compare domain.
    localparam logic [63:0] SIZE_MASK = {64{1'b1}} >> (64 - SIZE_BITS);

    // Request fields.
    localparam int REQ_SIZE_W = 32;
    localparam int TGT_W      = 6;
    localparam int SIZE_LSB   = 0;
    localparam int TGT_LSB    = SIZE_LSB + REQ_SIZE_W;
    localparam int IN_DATA_W  = ((TGT_LSB + TGT_W + 7) / 8) * 8;
    localparam int IN_USER_W  = 1;

    // Result fields.
    localparam int RES_IDX_W  = 6;
    localparam int STATUS_W   = 2;
    localparam int GRANT_LSB  = 0;
    localparam int RIDX_LSB   = GRANT_LSB + 1;
    localparam int STAT_LSB   = RIDX_LSB + RES_IDX_W;
    localparam int OUT_USED_W = STAT_LSB + STATUS_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Request kinds.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

    // Microcode step counter width.
    localparam int STEP_W = 4;

    // Jump conditions.
    localparam logic [3:0] C_ALWAYS    = 4'd0;
    localparam logic [3:0] C_NO_FIRE   = 4'd1;
    localparam logic [3:0] C_FREE      = 4'd2;
    localparam logic [3:0] C_ZERO      = 4'd3;
    localparam logic [3:0] C_SCAN_STAY = 4'd4;
    localparam logic [3:0] C_FIT       = 4'd5;
    localparam logic [3:0] C_FULL      = 4'd6;
    localparam logic [3:0] C_BAD_IDX   = 4'd7;
    localparam logic [3:0] C_LAST      = 4'd8;
    localparam logic [3:0] C_OUT_BUSY  = 4'd9;
    localparam logic [3:0] C_NEVER     = 4'd10;

    // Datapath operations.
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_ACCEPT   = 4'd1;
    localparam logic [3:0] OP_RD_FIRST = 4'd2;
    localparam logic [3:0] OP_SCAN     = 4'd3;
    localparam logic [3:0] OP_RD_TGT   = 4'd4;
    localparam logic [3:0] OP_APPEND   = 4'd5;
    localparam logic [3:0] OP_MARK     = 4'd6;
    localparam logic [3:0] OP_REUSE    = 4'd7;
    localparam logic [3:0] OP_REMOVE   = 4'd8;
    localparam logic [3:0] OP_OUTPUT   = 4'd9;

    // Sources of the result index.
    localparam logic [1:0] RI_ZERO = 2'd0;
    localparam logic [1:0] RI_PTR  = 2'd1;
    localparam logic [1:0] RI_CNT  = 2'd2;

    // One control word of the microprogram.
    typedef struct packed {
        logic [3:0]          cond;
        logic [STEP_W-1:0]   target;
        logic [3:0]          op;
        logic                res_load;
        logic                res_grant;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          res_idx;
    } ctrl_t;

    // Condition flags reported by the datapath.
    typedef struct packed {
        logic no_fire;
        logic is_free;
        logic zero_size;
        logic scan_stay;
        logic fit;
        logic full;
        logic bad_idx;
        logic last;
        logic out_busy;
    } flags_t;

endpackage

/* rtl/core/ffba_seq.sv */
module ffba_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  ffba_pkg::flags_t flags,
    output ffba_pkg::ctrl_t  ctrl
);
    import ffba_pkg::*;

    // Step labels of the microprogram.
    localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH = 4'd1;
    localparam logic [STEP_W-1:0] S_ALLOC    = 4'd2;
    localparam logic [STEP_W-1:0] S_SCAN     = 4'd3;
    localparam logic [STEP_W-1:0] S_SCAN_END = 4'd4;
    localparam logic [STEP_W-1:0] S_APPEND   = 4'd5;
    localparam logic [STEP_W-1:0] S_APP_WR   = 4'd6;
    localparam logic [STEP_W-1:0] S_FREE     = 4'd7;
    localparam logic [STEP_W-1:0] S_FREE_CHK = 4'd8;
    localparam logic [STEP_W-1:0] S_MARK     = 4'd9;
    localparam logic [STEP_W-1:0] S_REMOVE   = 4'd10;
    localparam logic [STEP_W-1:0] S_REUSE    = 4'd11;
    localparam logic [STEP_W-1:0] S_R_ZERO   = 4'd12;
    localparam logic [STEP_W-1:0] S_R_FULL   = 4'd13;
    localparam logic [STEP_W-1:0] S_R_BAD    = 4'd14;
    localparam logic [STEP_W-1:0] S_OUTPUT   = 4'd15;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              take_jump;

    function automatic ctrl_t mk(input logic [3:0] cond, input logic [STEP_W-1:0] target,
                                 input logic [3:0] op, input logic res_load,
                                 input logic res_grant, input logic [STATUS_W-1:0] res_status,
                                 input logic [1:0] res_idx);
        ctrl_t w;
        w.cond       = cond;
        w.target     = target;
        w.op         = op;
        w.res_load   = res_load;
        w.res_grant  = res_grant;
        w.res_status = res_status;
        w.res_idx    = res_idx;
        return w;
    endfunction

    // Control store. A jump is taken when its condition holds; otherwise the
    // counter advances. The output step is the last word, so it falls
    // through to idle by wrapping.
    function automatic ctrl_t rom_word(input logic [STEP_W-1:0] s);
        ctrl_t w;
        case (s)
            S_IDLE:     w = mk(C_NO_FIRE, S_IDLE, OP_ACCEPT, 1'b0, 1'b0, ST_OK, RI_ZERO);
            S_DISPATCH: w = mk(C_FREE, S_FREE, OP_NONE, 1'b0, 1'b0, ST_OK, RI_ZERO);
            S_ALLOC:    w = mk(C_ZERO, S_R_ZERO, OP_RD_FIRST, 1'b0, 1'b0, ST_OK, RI_ZERO);
            S_SCAN:     w = mk(C_SCAN_STAY, S_SCAN, OP_SCAN, 1'b0, 1'b0, ST_OK, RI_ZERO);
            S_SCAN_END: w = mk(C_FIT, S_REUSE, OP_NONE, 1'b0, 1'b0, ST_OK, RI_ZERO);
            S_APPEND:   w = mk(C_FULL, S_R_FULL, OP_NONE, 1'b0, 1'b0, ST_OK, RI_ZERO);
            S_APP_WR:   w = mk(C_ALWAYS, S_OUTPUT, OP_APPEND, 1'b1, 1'b1, ST_OK, RI_CNT);
            S_FREE:     w = mk(C_BAD_IDX, S_R_BAD, OP_RD_TGT, 1'b0, 1'b0, ST_OK, RI_ZERO);
            S_FREE_CHK: w = mk(C_LAST, S_REMOVE, OP_NONE, 1'b0, 1'b0, ST_OK, RI_ZERO);
            S_MARK:     w = mk(C_ALWAYS, S_OUTPUT, OP_MARK, 1'b1, 1'b1, ST_OK, RI_ZERO);
            S_REMOVE:   w = mk(C_ALWAYS, S_OUTPUT, OP_REMOVE, 1'b1, 1'b1, ST_OK, RI_ZERO);
            S_REUSE:    w = mk(C_ALWAYS, S_OUTPUT, OP_REUSE, 1'b1, 1'b1, ST_OK, RI_PTR);
            S_R_ZERO:   w = mk(C_ALWAYS, S_OUTPUT, OP_NONE, 1'b1, 1'b0, ST_ZERO, RI_ZERO);
            S_R_FULL:   w = mk(C_ALWAYS, S_OUTPUT, OP_NONE, 1'b1, 1'b0, ST_FULL, RI_ZERO);
            S_R_BAD:    w = mk(C_ALWAYS, S_OUTPUT, OP_NONE, 1'b1, 1'b0, ST_BADIDX, RI_ZERO);
            S_OUTPUT:   w = mk(C_OUT_BUSY, S_OUTPUT, OP_OUTPUT, 1'b0, 1'b0, ST_OK, RI_ZERO);
            default:    w = mk(C_NEVER, S_IDLE, OP_NONE, 1'b0, 1'b0, ST_OK, RI_ZERO);
        endcase
        return w;
    endfunction

    assign ctrl = rom_word(step_reg);

    // Condition select.
    always_comb
    begin
        case (ctrl.cond)
            C_ALWAYS:    take_jump = 1'b1;
            C_NO_FIRE:   take_jump = flags.no_fire;
            C_FREE:      take_jump = flags.is_free;
            C_ZERO:      take_jump = flags.zero_size;
            C_SCAN_STAY: take_jump = flags.scan_stay;
            C_FIT:       take_jump = flags.fit;
            C_FULL:      take_jump = flags.full;
            C_BAD_IDX:   take_jump = flags.bad_idx;
            C_LAST:      take_jump = flags.last;
            C_OUT_BUSY:  take_jump = flags.out_busy;
            default:     take_jump = 1'b0;
        endcase
    end

    assign step_next = take_jump ? ctrl.target : step_reg + 1'b1;

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* rtl/core/first_fit_block_allocator_unit.sv */
// Channel   Dir  Contents
// s_*       in   requests: tuser = req_type; tdata = req_size, target_index
// m_*       out  results:  tdata = granted, result_index, status
//
// One request is handled at a time by a microcoded sequencer.
// An allocate reads the first entry and scans the table entry by entry; it then reuses
// the first free entry that fits, appends a new one, or fails full. Zero-size allocates
// and bad-index frees are refused; a free removes the last entry and marks any other free.
// Reset empties the table at once (entry count cleared); no clearing pass is needed.
// One result may wait in the output register; a second holds the sequencer in its output step.
module first_fit_block_allocator_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata, from bit 0: req_size[31:0], target_index[37:32], zero pad
    input  logic [ffba_pkg::IN_DATA_W-1:0]     s_tdata,
    // tuser, from bit 0: req_type
    input  logic [ffba_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata, from bit 0: granted[0], result_index[6:1], status[8:7], zero pad
    output logic [ffba_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import ffba_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;

    // Latched request.
    logic                  type_reg;
    logic [REQ_SIZE_W-1:0] size_reg;
    logic [TGT_W-1:0]      idx_reg;

    // Table control.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] ptr_next;
    logic [CNT_W-1:0] ptr_inc;

    // Size table with its free mark in the top bit.
    logic [SIZE_BITS:0]   mem [MAX_BLOCKS];
    logic [SIZE_BITS:0]   rd_data_reg;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 rd_free;
    logic                 mem_we;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_waddr;
    logic [IDX_W-1:0]     mem_raddr;
    logic [SIZE_BITS:0]   mem_wdata;
    logic [IDX_W-1:0]     tgt_addr;

    // Result and output registers.
    logic                  res_grant_reg;
    logic [RES_IDX_W-1:0]  res_idx_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic in_fire;
    logic out_load;
    logic fit;
    logic over_size;

    ffba_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign s_tready = (ctrl.op == OP_ACCEPT);
    assign in_fire  = s_tvalid && s_tready;

    assign rd_size  = rd_data_reg[SIZE_BITS-1:0];
    assign rd_free  = rd_data_reg[SIZE_BITS];
    assign ptr_inc  = ptr_reg + 1'b1;
    assign tgt_addr = IDX_W'(idx_reg);

    // Fit test on the entry held in the read register; the pointer check keeps
    // entries past the end of the table out.
    assign fit       = rd_free && (64'(rd_size) >= 64'(size_reg)) && (ptr_reg < count_reg);
    assign over_size = 64'(size_reg) > SIZE_MASK;

    // Flags for the sequencer.
    always_comb
    begin
        flags.no_fire   = !in_fire;
        flags.is_free   = (type_reg == REQ_FREE);
        flags.zero_size = (size_reg == '0);
        flags.scan_stay = !fit && (ptr_inc < count_reg);
        flags.fit       = fit;
        flags.full      = over_size || (count_reg == CNT_W'(MAX_BLOCKS));
        flags.bad_idx   = 32'(idx_reg) >= 32'(count_reg);
        flags.last      = (32'(idx_reg) + 32'd1) == 32'(count_reg);
        flags.out_busy  = out_valid_reg && !m_tready;
    end

    // Table port and pointer control from the current operation.
    always_comb
    begin
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = tgt_addr;
        mem_raddr  = tgt_addr;
        mem_wdata  = {1'b0, rd_size};
        count_next = count_reg;
        ptr_next   = ptr_reg;
        case (ctrl.op)
            OP_ACCEPT:
            begin
                if (in_fire)
                begin
                    ptr_next = '0;
                end
            end
            OP_RD_FIRST:
            begin
                mem_re    = 1'b1;
                mem_raddr = ptr_reg[IDX_W-1:0];
            end
            OP_SCAN:
            begin
                if (!fit)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_inc[IDX_W-1:0];
                    ptr_next  = ptr_inc;
                end
            end
            OP_RD_TGT:
            begin
                mem_re = 1'b1;
            end
            OP_APPEND:
            begin
                mem_we     = 1'b1;
                mem_waddr  = count_reg[IDX_W-1:0];
                mem_wdata  = {1'b0, SIZE_BITS'(size_reg)};
                count_next = count_reg + 1'b1;
            end
            OP_MARK:
            begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, rd_size};
            end
            OP_REUSE:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[IDX_W-1:0];
            end
            OP_REMOVE:
            begin
                count_next = CNT_W'(idx_reg);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Table storage with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            type_reg <= s_tuser[0];
            size_reg <= s_tdata[SIZE_LSB +: REQ_SIZE_W];
            idx_reg  <= s_tdata[TGT_LSB +: TGT_W];
        end
    end

    // Entry count and scan pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Result fields, loaded by the finishing step of each request.
    always_ff @(posedge clk)
    begin
        if (ctrl.res_load)
        begin
            res_grant_reg  <= ctrl.res_grant;
            res_status_reg <= ctrl.res_status;
            case (ctrl.res_idx)
                RI_PTR:  res_idx_reg <= RES_IDX_W'(ptr_reg);
                RI_CNT:  res_idx_reg <= RES_IDX_W'(count_reg);
                default: res_idx_reg <= '0;
            endcase
        end
    end

    // Output register.
    assign out_load = (ctrl.op == OP_OUTPUT) && !flags.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= OUT_DATA_W'({res_status_reg, res_idx_reg, res_grant_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/core/ffba_check.sv */
`include "assert_macros.svh"

module ffba_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ffba_pkg::OUT_DATA_W-1:0] m_tdata
);
    import ffba_pkg::*;

    logic                 grant;
    logic [RES_IDX_W-1:0] res_idx;
    logic [STATUS_W-1:0]  status;
    logic                 in_fire;

    assign grant   = m_tdata[GRANT_LSB];
    assign res_idx = m_tdata[RIDX_LSB +: RES_IDX_W];
    assign status  = m_tdata[STAT_LSB +: STATUS_W];
    assign in_fire = s_tvalid && s_tready;

    // A stalled result holds its value.
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A granted result always carries the ok status.
    `ASSERT_IMPL(a_grant_ok, m_tvalid && grant, status == ST_OK)

    // A refused result hands out no index.
    `ASSERT_IMPL(a_refuse_idx, m_tvalid && !grant, res_idx == '0 && status != ST_OK)

    // Requests are worked one at a time: no accept in the cycle after an accept.
    `ASSERT_NEXT(a_one_at_a_time, in_fire, !s_tready)

endmodule

bind first_fit_block_allocator_unit ffba_check u_ffba_check (.*);
